@@ src/scsr_pkg.sv @@
// ----------------------------------------------------------------------------
// scsr_pkg
// Shared types and constants of the stepped current source regulator:
// payload structs, register indexes, sense range limits and reset values.
// ----------------------------------------------------------------------------
package scsr_pkg;

   localparam int unsigned SET_POINT_W = 15;
   localparam int unsigned MARGIN_W    = 10;
   localparam int unsigned STEP_W      = 10;
   localparam int unsigned SAMPLE_W    = 12;
   localparam int unsigned CURRENT_W   = 15;
   localparam int unsigned VOUT_W      = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 15;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_POINT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP      = 2'd2;

   // set point thresholds that pick the sense range
   localparam logic [SET_POINT_W-1:0] RANGE_1A_LIMIT  = 15'd800;
   localparam logic [SET_POINT_W-1:0] RANGE_5A_LIMIT  = 15'd4200;
   localparam logic [SET_POINT_W-1:0] RANGE_10A_LIMIT = 15'd8500;

   // regulator state codes as seen on the result channel
   localparam logic [1:0] STATE_OFF     = 2'd0;
   localparam logic [1:0] STATE_LOW     = 2'd1;
   localparam logic [1:0] STATE_HIGH    = 2'd2;
   localparam logic [1:0] STATE_REACHED = 2'd3;

   // ceil(2^18/3): exact floor(x/3) for x below 2^17
   localparam int unsigned    SCALED_W  = 17;
   localparam int unsigned    RECIP_W   = 18;
   localparam int unsigned    RECIP_SH  = 18;
   localparam logic [RECIP_W-1:0] RECIP_THIRD = 18'd87382;

   localparam logic [SET_POINT_W-1:0] SET_POINT_RESET = 15'd0;
   localparam logic [MARGIN_W-1:0]    MARGIN_RESET    = 10'd50;
   localparam logic [STEP_W-1:0]      STEP_RESET      = 10'd20;
   localparam logic [VOUT_W-1:0]      VOUT_CMD_RESET  = 16'd800;

   typedef struct packed {
      logic                new_sample;
      logic [SAMPLE_W-1:0] sample_mv;
   } req_type;

   typedef struct packed {
      logic [1:0]           regulator_state;
      logic                 output_enabled;
      logic                 vout_write;
      logic [VOUT_W-1:0]    vout_mv;
      logic [CURRENT_W-1:0] measured_ma;
   } rsp_type;

endpackage

@@ src/stepped_current_source_regulator.sv @@
// ----------------------------------------------------------------------------
// stepped_current_source_regulator
// Converts sense readings to mA and hunts the supply command toward the set
// point through four states: off, too low, too high and reached.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_stall  | new_sample, sample_mv
//  rsp_     | out       | rsp_valid/rsp_stall  | state, enable, vout write/mV, mA
//  csr_     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_stall is low; each passes the
// input register holding the converted current, then the result register.
// The reading-to-mA multiply sits before the input register; the state
// update and compares sit before the result register.
// Synchronous reset; the block is ready to accept after reset.
// rsp_stall holds the result register and backs up into req_stall only when
// the input register is also full. csr_ready drops while the input register holds a transaction.
module stepped_current_source_regulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  scsr_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output scsr_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scsr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      MODE_OFF     = scsr_pkg::STATE_OFF,
      MODE_LOW     = scsr_pkg::STATE_LOW,
      MODE_HIGH    = scsr_pkg::STATE_HIGH,
      MODE_REACHED = scsr_pkg::STATE_REACHED
   } mode_type;

   localparam int unsigned PROD_W = scsr_pkg::SCALED_W + scsr_pkg::RECIP_W;

   // configuration
   logic [scsr_pkg::SET_POINT_W-1:0] set_point_ff;
   logic [scsr_pkg::MARGIN_W-1:0]    margin_ff;
   logic [scsr_pkg::STEP_W-1:0]      step_ff;

   // input register
   logic                             in_valid_ff, in_valid_in;
   logic                             in_fresh_ff;
   logic [scsr_pkg::CURRENT_W-1:0]   in_current_ff;

   // regulator state and result register
   mode_type                         mode_ff, mode_in;
   logic [scsr_pkg::VOUT_W-1:0]      cmd_ff, cmd_in;
   logic [scsr_pkg::CURRENT_W-1:0]   latest_ff, latest_in;
   logic                             enable_ff, enable_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   scsr_pkg::rsp_type                rsp_ff, rsp_in;

   logic                             advance;
   logic                             req_accept;
   logic [scsr_pkg::SCALED_W-1:0]    mv_x5;
   logic [scsr_pkg::SCALED_W-1:0]    scaled;
   logic [PROD_W-1:0]                product;
   logic [scsr_pkg::CURRENT_W-1:0]   sample_ma;

   logic [scsr_pkg::CURRENT_W-1:0]   cur;
   logic [scsr_pkg::CURRENT_W:0]     sp_plus_m;
   logic [scsr_pkg::CURRENT_W:0]     cur_plus_m;
   logic [scsr_pkg::CURRENT_W-1:0]   diff;
   logic                             above, below, in_band;
   logic [scsr_pkg::VOUT_W:0]        cmd_up;
   logic                             sp_zero;
   logic                             wr;
   logic [scsr_pkg::VOUT_W-1:0]      vout;

   // ---------------------------------------------------------------- handshake
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready  = !in_valid_ff;

   // ------------------------------------------------------- reading to mA
   assign mv_x5 = {5'd0, req_payload.sample_mv} + {3'd0, req_payload.sample_mv, 2'd0};

   always_comb begin
      if (set_point_ff < scsr_pkg::RANGE_1A_LIMIT) begin
         scaled = {5'd0, req_payload.sample_mv};
      end else if (set_point_ff < scsr_pkg::RANGE_5A_LIMIT) begin
         scaled = mv_x5;
      end else if (set_point_ff < scsr_pkg::RANGE_10A_LIMIT) begin
         scaled = {mv_x5[scsr_pkg::SCALED_W-2:0], 1'b0};
      end else begin
         scaled = {mv_x5[scsr_pkg::SCALED_W-3:0], 2'b00};
      end
   end

   // divide by three through the reciprocal
   assign product   = {{scsr_pkg::RECIP_W{1'b0}}, scaled} *
                      {{scsr_pkg::SCALED_W{1'b0}}, scsr_pkg::RECIP_THIRD};
   assign sample_ma = product[scsr_pkg::RECIP_SH +: scsr_pkg::CURRENT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_fresh_ff   <= req_payload.new_sample;
         in_current_ff <= sample_ma;
      end
   end

   // ---------------------------------------------------------- config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         set_point_ff <= scsr_pkg::SET_POINT_RESET;
         margin_ff    <= scsr_pkg::MARGIN_RESET;
         step_ff      <= scsr_pkg::STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            scsr_pkg::CSR_SET_POINT: set_point_ff <= csr_wdata;
            scsr_pkg::CSR_MARGIN:    margin_ff    <= csr_wdata[scsr_pkg::MARGIN_W-1:0];
            scsr_pkg::CSR_STEP:      step_ff      <= csr_wdata[scsr_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------- regulator step
   assign cur        = in_fresh_ff ? in_current_ff : latest_ff;
   assign sp_plus_m  = {1'b0, set_point_ff} + {6'd0, margin_ff};
   assign cur_plus_m = {1'b0, cur} + {6'd0, margin_ff};
   assign diff       = (cur >= set_point_ff) ? (cur - set_point_ff) : (set_point_ff - cur);
   assign above      = {1'b0, cur} > sp_plus_m;
   assign below      = cur_plus_m < {1'b0, set_point_ff};
   assign in_band    = diff < {5'd0, margin_ff};
   assign cmd_up     = {1'b0, cmd_ff} + {7'd0, step_ff};
   assign sp_zero    = (set_point_ff == '0);

   always_comb begin
      mode_in   = mode_ff;
      cmd_in    = cmd_ff;
      enable_in = enable_ff;
      latest_in = cur;
      wr        = 1'b0;
      vout      = '0;
      unique case (mode_ff)
         MODE_OFF: begin
            if (!sp_zero) begin
               mode_in   = MODE_LOW;
               enable_in = 1'b1;
            end
         end
         MODE_LOW: begin
            if (sp_zero) begin
               mode_in   = MODE_OFF;
               enable_in = 1'b0;
               wr        = 1'b1;
            end else if (above) begin
               mode_in = MODE_HIGH;
            end else if (in_band) begin
               mode_in = MODE_REACHED;
            end else begin
               // raise, saturating at full scale
               cmd_in = cmd_up[scsr_pkg::VOUT_W] ? '1 : cmd_up[scsr_pkg::VOUT_W-1:0];
               wr     = 1'b1;
               vout   = cmd_in;
            end
         end
         MODE_HIGH: begin
            if (sp_zero) begin
               mode_in   = MODE_OFF;
               enable_in = 1'b0;
               wr        = 1'b1;
            end else if (below) begin
               mode_in = MODE_LOW;
            end else if (in_band) begin
               mode_in = MODE_REACHED;
            end else begin
               // lower, saturating at zero
               cmd_in = (cmd_ff > {6'd0, step_ff}) ? (cmd_ff - {6'd0, step_ff}) : '0;
               wr     = 1'b1;
               vout   = cmd_in;
            end
         end
         MODE_REACHED: begin
            if (sp_zero) begin
               mode_in   = MODE_OFF;
               enable_in = 1'b0;
            end else if (above) begin
               mode_in = MODE_HIGH;
            end else if (below) begin
               mode_in = MODE_LOW;
            end
         end
         default: ;
      endcase
      rsp_in.regulator_state = mode_in;
      rsp_in.output_enabled  = enable_in;
      rsp_in.vout_write      = wr;
      rsp_in.vout_mv         = vout;
      rsp_in.measured_ma     = latest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         cmd_ff       <= scsr_pkg::VOUT_CMD_RESET;
         latest_ff    <= '0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff   <= mode_in;
            cmd_ff    <= cmd_in;
            latest_ff <= latest_in;
            enable_ff <= enable_in;
            rsp_ff    <= rsp_in;
         end
      end
   end

`ifndef SYNTH
   a_off_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.vout_write &&
      rsp_payload.regulator_state == scsr_pkg::STATE_OFF |-> rsp_payload.vout_mv == '0)
      else $error("voltage write on entering off is not zero");

   a_enable_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.output_enabled ==
                    (rsp_payload.regulator_state != scsr_pkg::STATE_OFF))
      else $error("output enable disagrees with regulator state");

   a_no_write_when_reached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.regulator_state == scsr_pkg::STATE_REACHED
      |-> !rsp_payload.vout_write)
      else $error("voltage write while reached");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff) && $stable(mode_ff))
      else $error("stalled result or state changed");
`endif

endmodule
